[design/biphase_edge_frame_decoder_top_assert.svh]
// Assertion macros used by the biphase edge frame decoder back end (befd_back).
// Expects signals named clk and rst_n in the including module's scope.
`ifndef BIPHASE_EDGE_FRAME_DECODER_TOP_ASSERT_SVH
`define BIPHASE_EDGE_FRAME_DECODER_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define BEFD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BEFD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BEFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/befd_pkg.sv]
// Shared types and constants for the biphase edge frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package befd_pkg;

    localparam int FRAME_BYTES     = 18;
    localparam int MAX_MISSED_BITS = 32;
    localparam int MAX_BYTE_RES    = 5;

    localparam int RUN_W      = 6;
    localparam int BYTE_CNT_W = 3;
    localparam int DIV_W      = 32;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_STEP_W = $clog2(DIV_W);

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'hFE;
    localparam logic [7:0] SYNC_TYPE_A = 8'hD0;
    localparam logic [7:0] SYNC_TYPE_B = 8'h2F;

    localparam logic [15:0] HALF_BIT_RST    = 16'd1250;
    localparam logic [14:0] TOL_RST         = 15'd625;
    localparam logic [14:0] START_TOL_RST   = 15'd250;
    localparam logic [7:0]  START_EDGES_RST = 8'd28;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        CFG_HALF_BIT    = 2'd0,
        CFG_TOL         = 2'd1,
        CFG_START_TOL   = 2'd2,
        CFG_START_EDGES = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] edge_time_us;
    } req_t;

    typedef struct packed {
        logic       kind;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic       frame_started;
        logic       frame_done;
        logic       line_level;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] half_bit_us;
        logic [14:0] tolerance_us;
        logic [14:0] start_tolerance_us;
        logic [7:0]  start_edges;
    } cfg_t;

    // One edge decision: run_len bits of run_bit, then optionally one
    // inverted bit (phase change).
    typedef struct packed {
        logic             restart;
        logic [RUN_W-1:0] run_len;
        logic             run_bit;
        logic             tail;
        logic             started;
        logic             level;
    } cmd_t;

    typedef struct packed {
        logic feeding;
        logic done;
    } back_stat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_WAIT,
        F_DIFF,
        F_SUM,
        F_CLASS,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FEED,
        B_STATUS
    } back_state_t;

    typedef enum logic [1:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_SYNC2,
        PH_DATA
    } parse_phase_t;

endpackage

`default_nettype wire

[design/befd_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Uses befd_pkg widths; divisor must be nonzero and held during a divide.
`default_nettype none

module befd_div
    import befd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIV_W-1:0]      quo_reg;

    logic [DIVISOR_W:0] cand;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    assign cand = {rem_reg, quo_reg[DIV_W-1]};
    assign ge   = cand >= {1'b0, divisor};
    assign diff = cand - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == DIV_STEP_W'(DIV_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(DIV_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : cand[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[design/befd_front.sv]
// Front end: accepts transactions, tracks edge timing and classifies each
// interval into a bit command. Depends on befd_pkg and befd_div.
`default_nettype none

module befd_front
    import befd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    input  wire back_stat_t back_stat,
    input  wire logic       q_empty,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_t            q_cmd
);

    front_state_t state_reg, state_next;

    logic [31:0]      time_reg;
    logic [31:0]      last_time_reg;
    logic             level_reg;
    logic [7:0]       start_cnt_reg;
    logic             started_reg;
    logic             half_seen_reg;
    logic             bit_val_reg;
    logic [31:0]      d_reg;
    logic [32:0]      dtol_reg;
    logic [32:0]      dst_reg;
    logic [16:0]      hst_reg;
    logic [16:0]      htol_reg;
    logic [16:0]      h2_reg;
    logic [17:0]      h2tol_reg;
    logic             restart_reg;
    logic [RUN_W-1:0] run_len_reg;
    logic             run_bit_reg;
    logic             tail_reg;

    logic [15:0]      h_eff;
    logic             in_win;
    logic             debounce;
    logic             same_phase;
    logic             phase_chg;
    logic [7:0]       start_inc;
    logic             div_start;
    logic             div_done;
    logic [DIV_W-1:0] quotient;
    logic [RUN_W-1:0] miss_len;

    // zero half-bit period acts as one
    assign h_eff = (cfg.half_bit_us == '0) ? 16'd1 : cfg.half_bit_us;

    assign in_win     = (dst_reg >= 33'(h_eff)) && (33'(d_reg) < 33'(hst_reg));
    assign debounce   = dtol_reg <= 33'(h_eff);
    assign same_phase = 33'(d_reg) < 33'(htol_reg);
    assign phase_chg  = (dtol_reg >= 33'(h2_reg)) && (33'(d_reg) < 33'(h2tol_reg));
    assign start_inc  = (start_cnt_reg == 8'hFF) ? 8'hFF : start_cnt_reg + 8'd1;

    assign div_start = (state_reg == F_CLASS) && started_reg && !back_stat.done
                       && !debounce && !same_phase && !phase_chg;

    // missed bits = quotient/2, capped
    assign miss_len = ((|quotient[DIV_W-1:RUN_W+1])
                       || (quotient[RUN_W:1] > RUN_W'(MAX_MISSED_BITS)))
                      ? RUN_W'(MAX_MISSED_BITS) : quotient[RUN_W:1];

    befd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_reg),
        .divisor  (h_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    state_next = (req.opcode == OP_RESTART) ? F_PUSH : F_WAIT;
            end
            F_WAIT:
            begin
                // done flag is final only once the back end has drained
                if (q_empty && !back_stat.feeding)
                    state_next = F_DIFF;
            end
            F_DIFF:  state_next = F_SUM;
            F_SUM:   state_next = F_CLASS;
            F_CLASS: state_next = div_start ? F_DIV : F_PUSH;
            F_DIV:
            begin
                if (div_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    assign q_cmd = '{restart: restart_reg, run_len: run_len_reg, run_bit: run_bit_reg,
                     tail: tail_reg, started: started_reg, level: level_reg};

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            level_reg     <= 1'b0;
            start_cnt_reg <= '0;
            started_reg   <= 1'b0;
            half_seen_reg <= 1'b1;
            bit_val_reg   <= 1'b1;
            restart_reg   <= 1'b0;
            run_len_reg   <= '0;
            run_bit_reg   <= 1'b0;
            tail_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (req_valid)
                    begin
                        run_len_reg <= '0;
                        tail_reg    <= 1'b0;
                        if (req.opcode == OP_RESTART)
                        begin
                            restart_reg   <= 1'b1;
                            start_cnt_reg <= '0;
                            started_reg   <= 1'b0;
                            half_seen_reg <= 1'b1;
                            bit_val_reg   <= 1'b1;
                        end
                        else
                        begin
                            restart_reg <= 1'b0;
                            level_reg   <= ~level_reg;
                        end
                    end
                end
                F_CLASS:
                begin
                    // start-like edges feed a one bit
                    run_bit_reg <= (!started_reg && in_win) ? 1'b1 : bit_val_reg;
                    if (!started_reg)
                    begin
                        last_time_reg <= time_reg;
                        if (in_win)
                        begin
                            start_cnt_reg <= start_inc;
                            run_len_reg   <= RUN_W'(1);
                            if (start_inc >= cfg.start_edges)
                                started_reg <= 1'b1;
                        end
                        else
                        begin
                            start_cnt_reg <= '0;
                        end
                    end
                    else if (!back_stat.done && !debounce)
                    begin
                        last_time_reg <= time_reg;
                        if (same_phase)
                        begin
                            run_len_reg   <= half_seen_reg ? RUN_W'(0) : RUN_W'(1);
                            half_seen_reg <= ~half_seen_reg;
                        end
                        else if (phase_chg)
                        begin
                            tail_reg      <= 1'b1;
                            bit_val_reg   <= ~bit_val_reg;
                            half_seen_reg <= 1'b0;
                        end
                    end
                end
                F_DIV:
                begin
                    if (div_done)
                    begin
                        run_len_reg <= miss_len;
                        tail_reg    <= quotient[0];
                        if (quotient[0])
                        begin
                            bit_val_reg   <= ~bit_val_reg;
                            half_seen_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // interval arithmetic, split over the F_DIFF and F_SUM states
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req_valid)
            time_reg <= req.edge_time_us;
        if (state_reg == F_DIFF)
        begin
            d_reg     <= time_reg - last_time_reg;
            hst_reg   <= 17'(h_eff) + 17'(cfg.start_tolerance_us);
            htol_reg  <= 17'(h_eff) + 17'(cfg.tolerance_us);
            h2_reg    <= {h_eff, 1'b0};
            h2tol_reg <= 18'({h_eff, 1'b0}) + 18'(cfg.tolerance_us);
        end
        if (state_reg == F_SUM)
        begin
            dtol_reg <= 33'(d_reg) + 33'(cfg.tolerance_us);
            dst_reg  <= 33'(d_reg) + 33'(cfg.start_tolerance_us);
        end
    end

endmodule

`default_nettype wire

[design/befd_cmdq.sv]
// Two-entry command queue between the front and back ends.
// Depends on befd_pkg for the command type.
`default_nettype none

module befd_cmdq
    import befd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

[design/befd_back.sv]
// Back end: feeds command bits through the frame parser (one bit per cycle, unless a
// byte result waits) and drives the result register. Depends on befd_pkg and the assert macros.
`default_nettype none
`include "biphase_edge_frame_decoder_top_assert.svh"

module befd_back
    import befd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    output back_stat_t stat,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    back_state_t state_reg, state_next;

    logic                  started_reg;
    logic                  level_reg;
    logic [RUN_W-1:0]      run_left_reg;
    logic                  run_bit_reg;
    logic                  tail_reg;
    logic                  done_reg;
    parse_phase_t          phase_reg;
    logic [2:0]            bit_pos_reg;
    logic [7:0]            shift_reg;
    logic [4:0]            byte_pos_reg;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg;
    logic                  out_valid_reg;
    rsp_t                  out_reg;

    logic         out_free;
    logic         have_bit;
    logic         cur_bit;
    logic [7:0]   sh;
    logic         wr;
    logic [4:0]   wr_idx;
    parse_phase_t phase_n;
    logic [2:0]   bit_pos_n;
    logic         emit;
    logic         advance;

    assign out_free = !out_valid_reg || rsp_ready;
    assign have_bit = (run_left_reg != '0) || tail_reg;
    assign cur_bit  = (run_left_reg != '0) ? run_bit_reg : ~run_bit_reg;
    assign sh       = {shift_reg[6:0], cur_bit};

    // parser step for the current bit
    always_comb
    begin
        wr        = 1'b0;
        wr_idx    = byte_pos_reg;
        phase_n   = phase_reg;
        bit_pos_n = bit_pos_reg;
        unique case (phase_reg)
            PH_SYNC0:
            begin
                if (sh == SYNC_FIRST)
                begin
                    wr      = 1'b1;
                    wr_idx  = 5'd0;
                    phase_n = PH_SYNC1;
                end
            end
            PH_SYNC1:
            begin
                if (sh == SYNC_SECOND)
                begin
                    wr      = 1'b1;
                    wr_idx  = 5'd1;
                    phase_n = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (sh == SYNC_TYPE_A || sh == SYNC_TYPE_B)
                begin
                    wr      = 1'b1;
                    wr_idx  = 5'd2;
                    phase_n = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (bit_pos_reg == 3'd7)
                    wr = 1'b1;
                else
                    bit_pos_n = bit_pos_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign emit    = wr && !done_reg && (byte_cnt_reg < BYTE_CNT_W'(MAX_BYTE_RES));
    // a byte result waits for the output register
    assign advance = (state_reg == B_FEED) && have_bit && (!emit || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_FEED;
                end
            end
            B_FEED:
            begin
                if (!have_bit)
                    state_next = B_STATUS;
            end
            B_STATUS:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            level_reg     <= 1'b0;
            run_left_reg  <= '0;
            run_bit_reg   <= 1'b0;
            tail_reg      <= 1'b0;
            done_reg      <= 1'b0;
            phase_reg     <= PH_SYNC0;
            bit_pos_reg   <= '0;
            shift_reg     <= '0;
            byte_pos_reg  <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((advance && emit) || (state_reg == B_STATUS && out_free))
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;

            if (q_pop)
            begin
                started_reg  <= q_head.started;
                level_reg    <= q_head.level;
                run_left_reg <= q_head.run_len;
                run_bit_reg  <= q_head.run_bit;
                tail_reg     <= q_head.tail;
                byte_cnt_reg <= '0;
                if (q_head.restart)
                begin
                    done_reg     <= 1'b0;
                    phase_reg    <= PH_SYNC0;
                    bit_pos_reg  <= '0;
                    shift_reg    <= '0;
                    byte_pos_reg <= '0;
                end
            end

            if (advance)
            begin
                if (run_left_reg != '0)
                    run_left_reg <= run_left_reg - 1'b1;
                else
                    tail_reg <= 1'b0;
                if (!done_reg)
                begin
                    phase_reg <= phase_n;
                    if (wr)
                    begin
                        shift_reg    <= '0;
                        bit_pos_reg  <= '0;
                        byte_pos_reg <= wr_idx + 5'd1;
                        if ((6'(wr_idx) + 6'd1) >= 6'(FRAME_BYTES))
                            done_reg <= 1'b1;
                    end
                    else
                    begin
                        shift_reg   <= sh;
                        bit_pos_reg <= bit_pos_n;
                    end
                end
                if (emit)
                    byte_cnt_reg <= byte_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_reg <= '{kind: KIND_BYTE, byte_index: wr_idx, byte_value: sh,
                         frame_started: 1'b0, frame_done: 1'b0, line_level: 1'b0,
                         last: 1'b0};
        else if (state_reg == B_STATUS && out_free)
            out_reg <= '{kind: KIND_STATUS, byte_index: 5'd0, byte_value: 8'd0,
                         frame_started: started_reg, frame_done: done_reg,
                         line_level: level_reg, last: 1'b1};
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign stat      = '{feeding: (state_reg == B_FEED), done: done_reg};

    `BEFD_ASSERT_IMPLY(a_done_in_data, done_reg, phase_reg == PH_DATA, "done outside data phase")
    `BEFD_ASSERT_ALWAYS(a_byte_res_cap, byte_cnt_reg <= BYTE_CNT_W'(MAX_BYTE_RES), "too many bytes")
    `BEFD_ASSERT_NEXT(a_status_out, state_reg == B_STATUS && out_free, rsp_valid && rsp.last, "status lost")

endmodule

`default_nettype wire

[design/biphase_edge_frame_decoder_top.sv]
// Biphase-L edge decoder with frame sync. Transactions on req carry either a
// line edge (opcode 0, microsecond timestamp) or a restart (opcode 1). Each
// accepted transaction yields zero to five frame-byte results on rsp, then
// exactly one status result with last set.
// Flow: the front end classifies each edge and, when the interval spans missed edges,
// also runs the serial divider (one quotient bit a cycle). The back end then picks up
// the command and feeds one recovered bit per cycle (up to 33 bits), writing byte
// results as it goes, and closes with the status result. The front end waits for
// the back end to drain before classifying an edge, since classification needs the
// final frame-done flag; a two-entry queue lets the next transaction be taken while
// results still wait.
// Stalling rsp_ready holds the result register and pauses bit feeding;
// nothing is dropped. Reset restores default timing registers and clears all
// decoder state; req is ready as soon as reset is released.
// Config: cfg_we writes cfg_data into register cfg_index at once.
// Depends on befd_pkg, befd_front, befd_div, befd_cmdq, befd_back.
`default_nettype none

module biphase_edge_frame_decoder_top
    import befd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp
);

    cfg_t       cfg_reg;
    back_stat_t back_stat;
    cmd_t       push_cmd;
    cmd_t       head_cmd;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_us        <= HALF_BIT_RST;
            cfg_reg.tolerance_us       <= TOL_RST;
            cfg_reg.start_tolerance_us <= START_TOL_RST;
            cfg_reg.start_edges        <= START_EDGES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_BIT:    cfg_reg.half_bit_us        <= cfg_data;
                CFG_TOL:         cfg_reg.tolerance_us       <= cfg_data[14:0];
                CFG_START_TOL:   cfg_reg.start_tolerance_us <= cfg_data[14:0];
                CFG_START_EDGES: cfg_reg.start_edges        <= cfg_data[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    befd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .back_stat (back_stat),
        .q_empty   (q_empty),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    befd_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    befd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .stat      (back_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
